// File: rtl/core/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared constants, types and helpers of the linear interpolation resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

  // data path sizes
  localparam int NUM_CHANNELS          = 2;
  localparam int SAMPLE_BITS           = 24;
  localparam int FRAC_BITS             = 16;
  localparam int POS_BITS              = 32;
  localparam int RATE_BITS             = 21;
  localparam int STEP_BITS             = 18;
  localparam int LIMIT_BITS            = 16;
  localparam int IDX_BITS              = 16;
  localparam int MAX_OUTPUTS_PER_INPUT = 64;
  localparam int CNT_BITS              = $clog2(MAX_OUTPUTS_PER_INPUT + 1);
  localparam int DIFF_BITS             = SAMPLE_BITS + 1;
  localparam int PROD_BITS             = DIFF_BITS + FRAC_BITS + 1;
  localparam int RSUM_BITS             = RATE_BITS + 2;

  // configuration port
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_POSITION = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_RATE     = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATE_SLOPE     = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_LIMIT      = 8'd3;

  // rate range and reset value
  localparam logic [RATE_BITS-1:0] RATE_MIN       = 21'd1024;
  localparam logic [RATE_BITS-1:0] RATE_MAX       = 21'd1048576;
  localparam logic [RATE_BITS-1:0] START_RATE_RST = 21'd65536;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lirs_state_e;

  // sequencer to lanes
  typedef struct packed {
    logic                 restart;
    logic                 load_first;
    logic                 load_frame;
    logic                 frame_end;
    logic                 issue;
    logic [FRAC_BITS-1:0] frac;
  } lirs_lane_ctl_t;

  // sequencer to merge stage
  typedef struct packed {
    logic issue;
    logic last;
    logic fin;
  } lirs_issue_t;

  // clamp a signed rate value into the allowed range
  function automatic logic [RATE_BITS-1:0] sat_rate(input logic signed [RSUM_BITS-1:0] r);
    logic signed [RSUM_BITS-1:0] lo;
    logic signed [RSUM_BITS-1:0] hi;
    lo = $signed({2'b00, RATE_MIN});
    hi = $signed({2'b00, RATE_MAX});
    if (r < lo) begin
      return RATE_MIN;
    end else if (r > hi) begin
      return RATE_MAX;
    end else begin
      return r[RATE_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/linear_interp_resampler_unit.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Streaming linear-interpolation resampler with a variable rate.
// ----------------------------------------------------------------------------
// Usage:
//   Source frames come in on the in_* channel (valid/ready), one frame per
//   request. Each frame yields zero or more interpolated frames on the out_*
//   channel (valid/ready); last_of_run marks the last one a frame causes and
//   finished marks the end of the run.
//   Registers start_position, start_rate, the rate slope and out_limit are
//   written on the cfg_* channel (index 0 to 3), by the user only while the
//   block is idle; the block does not enforce it. A write to one of them
//   restarts the run; cfg_ready_o is always high. Flow: a frame is taken,
//   then the sequencer issues one output per cycle to the channel lanes
//   while the output path can take it, then closes the frame; a frame has
//   at most 64 outputs. After issue, each output passes the lane product
//   stage, then the output register, where the base sample is added.
//   If the receiver stalls, the product stage and output register fill and
//   the sequencer holds; no output is lost. in_ready_o stays low while a
//   frame is at work.
//   Reset clears the run state and loads the default registers; the block
//   is ready for a frame as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler_unit import lirs_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_right_i,
  input  wire logic                          end_of_source_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      out_left_o,
  output logic signed [SAMPLE_BITS-1:0]      out_right_o,
  output logic                               last_of_run_o,
  output logic                               finished_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data_i
);

  lirs_lane_ctl_t lane_ctl;
  lirs_issue_t    issue;
  logic           issue_ok;
  logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] samples;
  logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] lane_res;
  logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] out_samples;

  assign samples[0] = sample_left_i;
  assign samples[1] = sample_right_i;

  // sequencer and configuration
  lirs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .end_of_source_i (end_of_source_i),
    .in_ready_o      (in_ready_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cfg_ready_o     (cfg_ready_o),
    .issue_ok_i      (issue_ok),
    .lane_ctl_o      (lane_ctl),
    .issue_o         (issue)
  );

  // one interpolation lane per channel
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    lirs_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .sample_i (samples[c]),
      .result_o (lane_res[c])
    );
  end

  // output frame assembly
  lirs_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .lane_res_i   (lane_res),
    .out_ready_i  (out_ready_i),
    .issue_ok_o   (issue_ok),
    .out_valid_o  (out_valid_o),
    .out_sample_o (out_samples),
    .out_last_o   (last_of_run_o),
    .out_fin_o    (finished_o)
  );

  assign out_left_o  = out_samples[0];
  assign out_right_o = out_samples[1];

endmodule

`default_nettype wire

// File: rtl/core/lirs_lane.sv
// ----------------------------------------------------------------------------
// lirs_lane
// One channel: keeps the previous and current sample, multiplies the
// fraction by their difference and forms the interpolated sample.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_lane import lirs_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lirs_lane_ctl_t                ctl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0]      result_o
);

  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic signed [DIFF_BITS-1:0]   diff_q;
  logic signed [DIFF_BITS-1:0]   diff_d;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [SAMPLE_BITS-1:0] s1_prev_q;
  logic signed [PROD_BITS-1:0]   prod_shr;
  logic signed [PROD_BITS-1:0]   sum;

  // previous frame sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (ctl_i.restart) begin
      prev_q <= '0;
    end else if (ctl_i.load_first) begin
      prev_q <= sample_i;
    end else if (ctl_i.frame_end) begin
      prev_q <= cur_q;
    end
  end

  assign diff_d = DIFF_BITS'(sample_i) - DIFF_BITS'(prev_q);

  // current sample and difference for the frame at work
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_frame) begin
      cur_q  <= sample_i;
      diff_q <= diff_d;
    end
  end

  // product stage, taken with the base sample it belongs to
  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      prod_q    <= PROD_BITS'($signed({1'b0, ctl_i.frac}) * diff_q);
      s1_prev_q <= prev_q;
    end
  end

  // floor by the fraction width, then add the base sample
  assign prod_shr = prod_q >>> FRAC_BITS;
  assign sum      = PROD_BITS'(s1_prev_q) + prod_shr;
  assign result_o = sum[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/core/lirs_merge.sv
// ----------------------------------------------------------------------------
// lirs_merge
// Collects the lane results and the run flags into one output frame and
// holds it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_merge import lirs_pkg::*; (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire lirs_issue_t                            issue_i,
  input  wire logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] lane_res_i,
  input  wire logic                                   out_ready_i,
  output logic                                        issue_ok_o,
  output logic                                        out_valid_o,
  output logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0]    out_sample_o,
  output logic                                        out_last_o,
  output logic                                        out_fin_o
);

  logic s1_valid_q;
  logic s1_last_q;
  logic s1_fin_q;
  logic out_valid_q;
  logic out_free;
  logic s1_adv;
  logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] out_sample_q;
  logic out_last_q;
  logic out_fin_q;

  // pipeline advance
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign issue_ok_o = !s1_valid_q || out_free;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue_i.issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // flags that travel beside the lane products
  always_ff @(posedge clk_i) begin
    if (issue_i.issue) begin
      s1_last_q <= issue_i.last;
      s1_fin_q  <= issue_i.fin;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_sample_q <= lane_res_i;
      out_last_q   <= s1_last_q;
      out_fin_q    <= s1_fin_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;
  assign out_fin_o    = out_fin_q;

endmodule

`default_nettype wire

// File: rtl/core/lirs_ctrl.sv
// ----------------------------------------------------------------------------
// lirs_ctrl
// Configuration registers and the per-frame sequencer: walks the read
// position across the current frame pair, one output per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_ctrl import lirs_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     end_of_source_i,
  output logic                          in_ready_o,
  input  wire logic                     cfg_valid_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output logic                          cfg_ready_o,
  input  wire logic                     issue_ok_i,
  output lirs_lane_ctl_t                lane_ctl_o,
  output lirs_issue_t                   issue_o
);

  // configuration
  logic [POS_BITS-1:0]          start_pos_q, start_pos_d;
  logic [RATE_BITS-1:0]         start_rate_q, start_rate_d;
  logic signed [STEP_BITS-1:0]  rate_slope_q, rate_slope_d;
  logic [LIMIT_BITS-1:0]        out_limit_q, out_limit_d;

  // run state
  lirs_state_e                  state_q, state_d;
  logic [POS_BITS-1:0]          pos_q, pos_d;
  logic [RATE_BITS-1:0]         rate_q, rate_d;
  logic [IDX_BITS-1:0]          idx_q, idx_d;
  logic [LIMIT_BITS-1:0]        made_q, made_d;
  logic [CNT_BITS-1:0]          n_q, n_d;
  logic                         done_q, done_d;
  logic                         ovf_q, ovf_d;
  logic                         eos_q, eos_d;

  logic                         cfg_hit;
  logic [IDX_BITS-1:0]          target;
  logic                         cond;
  logic                         cond_next;
  logic [POS_BITS:0]            np;
  logic [LIMIT_BITS:0]          made_inc;
  logic signed [RSUM_BITS-1:0]  rate_sum;
  logic                         eos_in;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit = (cfg_index_i == REG_START_POSITION) || (cfg_index_i == REG_START_RATE) ||
                   (cfg_index_i == REG_RATE_SLOPE) || (cfg_index_i == REG_OUT_LIMIT);

  // per-output arithmetic
  assign target   = idx_q - 1'b1;
  assign np       = {1'b0, pos_q} + (POS_BITS + 1)'(rate_q);
  assign made_inc = {1'b0, made_q} + 1'b1;
  assign rate_sum = $signed({2'b00, rate_q}) +
                    $signed({{(RSUM_BITS - STEP_BITS){rate_slope_q[STEP_BITS-1]}}, rate_slope_q});
  assign eos_in   = end_of_source_i || (idx_q == '1);

  assign cond = (n_q < CNT_BITS'(MAX_OUTPUTS_PER_INPUT)) && (made_q < out_limit_q) &&
                !ovf_q && (pos_q[POS_BITS-1:FRAC_BITS] <= target);
  assign cond_next = (n_q < CNT_BITS'(MAX_OUTPUTS_PER_INPUT - 1)) &&
                     (made_inc < {1'b0, out_limit_q}) && !np[POS_BITS] &&
                     (np[POS_BITS-1:FRAC_BITS] <= target);

  // next state and outputs
  always_comb begin
    start_pos_d  = start_pos_q;
    start_rate_d = start_rate_q;
    rate_slope_d = rate_slope_q;
    out_limit_d  = out_limit_q;
    state_d      = state_q;
    pos_d        = pos_q;
    rate_d       = rate_q;
    idx_d        = idx_q;
    made_d       = made_q;
    n_d          = n_q;
    done_d       = done_q;
    ovf_d        = ovf_q;
    eos_d        = eos_q;
    in_ready_o   = 1'b0;
    lane_ctl_o   = '0;
    lane_ctl_o.frac = pos_q[FRAC_BITS-1:0];
    issue_o      = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !done_q) begin
          if (idx_q == '0) begin
            // first frame only primes the previous sample
            lane_ctl_o.load_first = 1'b1;
            idx_d = IDX_BITS'(1);
            if (eos_in || (out_limit_q == '0)) begin
              done_d = 1'b1;
            end
          end else begin
            lane_ctl_o.load_frame = 1'b1;
            eos_d   = eos_in;
            n_d     = '0;
            ovf_d   = 1'b0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (cond) begin
          if (issue_ok_i) begin
            lane_ctl_o.issue = 1'b1;
            issue_o.issue = 1'b1;
            issue_o.last  = !cond_next;
            issue_o.fin   = !cond_next &&
                            (eos_q || np[POS_BITS] || (made_inc >= {1'b0, out_limit_q}));
            pos_d  = np[POS_BITS-1:0];
            ovf_d  = np[POS_BITS];
            rate_d = sat_rate(rate_sum);
            made_d = made_inc[LIMIT_BITS-1:0];
            n_d    = n_q + 1'b1;
          end
        end else begin
          // frame finished: close the run if needed and shift the frame
          done_d = eos_q || ovf_q || (made_q >= out_limit_q);
          lane_ctl_o.frame_end = 1'b1;
          if (idx_q != '1) begin
            idx_d = idx_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register write restarts the run
    if (cfg_valid_i && cfg_hit) begin
      if (cfg_index_i == REG_START_POSITION) begin
        start_pos_d = cfg_data_i[POS_BITS-1:0];
      end
      if (cfg_index_i == REG_START_RATE) begin
        start_rate_d = cfg_data_i[RATE_BITS-1:0];
      end
      if (cfg_index_i == REG_RATE_SLOPE) begin
        rate_slope_d = $signed(cfg_data_i[STEP_BITS-1:0]);
      end
      if (cfg_index_i == REG_OUT_LIMIT) begin
        out_limit_d = cfg_data_i[LIMIT_BITS-1:0];
      end
      lane_ctl_o.restart = 1'b1;
      pos_d   = start_pos_d;
      rate_d  = sat_rate($signed({2'b00, start_rate_d}));
      idx_d   = '0;
      made_d  = '0;
      done_d  = 1'b0;
      state_d = ST_IDLE;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pos_q  <= '0;
      start_rate_q <= START_RATE_RST;
      rate_slope_q <= '0;
      out_limit_q  <= '0;
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      rate_q       <= START_RATE_RST;
      idx_q        <= '0;
      made_q       <= '0;
      n_q          <= '0;
      done_q       <= 1'b0;
      ovf_q        <= 1'b0;
      eos_q        <= 1'b0;
    end else begin
      start_pos_q  <= start_pos_d;
      start_rate_q <= start_rate_d;
      rate_slope_q <= rate_slope_d;
      out_limit_q  <= out_limit_d;
      state_q      <= state_d;
      pos_q        <= pos_d;
      rate_q       <= rate_d;
      idx_q        <= idx_d;
      made_q       <= made_d;
      n_q          <= n_d;
      done_q       <= done_d;
      ovf_q        <= ovf_d;
      eos_q        <= eos_d;
    end
  end

`ifndef SYNTH
  // never issue past the output limit
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_o.issue |-> (made_q < out_limit_q))
    else $error("output issued beyond limit");

  // issued positions lie inside the current frame pair
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_o.issue |-> (pos_q[POS_BITS-1:FRAC_BITS] <= target) && (idx_q != '0))
    else $error("output issued outside frame pair");

  // rate stays in range
  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rate_q >= RATE_MIN) && (rate_q <= RATE_MAX))
    else $error("rate out of range");

  // no more than the per-frame cap of outputs
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_o.issue |-> (n_q < CNT_BITS'(MAX_OUTPUTS_PER_INPUT)) && (state_q == ST_RUN))
    else $error("per-frame output cap exceeded");
`endif

endmodule

`default_nettype wire
